[sv/swpec_pkg.sv]
package swpec_pkg;

  localparam int WINDOW_DEPTH = 1024;
  localparam int PTR_W        = $clog2(WINDOW_DEPTH);
  localparam int FILL_W       = $clog2(WINDOW_DEPTH + 1);

  localparam int TS_W     = 22;
  localparam int CNT_W    = 11;
  localparam int ERR_W    = 32;
  localparam int CLASS_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MIN_W    = 6;
  localparam int SEC_W    = 6;
  localparam int OPND_W   = 6;
  localparam int WGT_W    = 17;
  localparam int PROD_W   = OPND_W + WGT_W;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 80;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = TS_W;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ERR_CLASS = 1'd1;
  localparam logic [CLASS_W-1:0]   ERR_CLASS_RST = 4'd5;

  localparam int STEP_W = 2;
  localparam logic [STEP_W-1:0] STEP_DAY  = 2'd0;
  localparam logic [STEP_W-1:0] STEP_HOUR = 2'd1;
  localparam logic [STEP_W-1:0] STEP_MIN  = 2'd2;
  localparam logic [STEP_W-1:0] STEP_SEC  = 2'd3;

  localparam logic [WGT_W-1:0] SECS_PER_DAY  = 17'd86400;
  localparam logic [WGT_W-1:0] SECS_PER_HOUR = 17'd3600;
  localparam logic [WGT_W-1:0] SECS_PER_MIN  = 17'd60;
  localparam logic [WGT_W-1:0] SECS_PER_SEC  = 17'd1;

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    next_ptr = (p == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [WGT_W-1:0] step_weight(input logic [STEP_W-1:0] s);
    logic [WGT_W-1:0] w;
    unique case (s)
      STEP_DAY:  w = SECS_PER_DAY;
      STEP_HOUR: w = SECS_PER_HOUR;
      STEP_MIN:  w = SECS_PER_MIN;
      default:   w = SECS_PER_SEC;
    endcase
    step_weight = w;
  endfunction

endpackage

[sv/sliding_window_peak_event_count.sv]
// Sliding-window event counter for log records. Each record (day, hour, minute, second,
// status class) is turned into a seconds timestamp and pushed into a 1024-entry timestamp
// store; entries older than window_seconds before it are retired first, and the result
// carries the timestamp, the count in the window ending at this record, the peak count
// since reset, a saturating error count and an overflow flag for a forced drop. One
// record passes through these steps in order: the accept step, the multiply-add steps
// for day, hour, minute and second on the shared unit that builds the timestamp, a
// compare per retire candidate, with a settle step after each retire that waits on the
// registered read port of the store, a push step and a result step, which is held for
// as long as the previous result still waits in the output register.
// in_tready is low while a record is in flight; a result may wait in the output register
// while the next record is taken. Timestamps are expected in non-decreasing order.
module sliding_window_peak_event_count
  import swpec_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // day[4:0], hour[9:5], minute[15:10], second[21:16], status_class[25:22], zero pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // timestamp_seconds[21:0], in_window_count[32:22], peak_count[43:33],
  // error_total[75:44], overflow_flag[76], zero pad
  output logic [OUT_DATA_W-1:0] out_tdata
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_SCAN,
    S_SETTLE,
    S_PUSH,
    S_EMIT
  } state_t;

  state_t state_r;

  logic [TS_W-1:0]    window_r;
  logic [CLASS_W-1:0] err_class_r;

  logic [DAY_W-1:0]   day_r;
  logic [HOUR_W-1:0]  hour_r;
  logic [MIN_W-1:0]   min_r;
  logic [SEC_W-1:0]   sec_r;
  logic [CLASS_W-1:0] class_r;
  logic [STEP_W-1:0]  step_r;
  logic [TS_W-1:0]    acc_r;

  logic [PTR_W-1:0]   oldest_r;
  logic [PTR_W-1:0]   newest_r;
  logic [FILL_W-1:0]  fill_r;
  logic [FILL_W-1:0]  peak_r;
  logic [ERR_W-1:0]   err_r;
  logic               ovf_r;

  logic [TS_W-1:0]    store_mem [WINDOW_DEPTH];
  logic [TS_W-1:0]    rd_q;
  logic               mem_we;

  logic               out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;

  logic [OPND_W-1:0]  opnd;
  logic [PROD_W-1:0]  prod;
  logic [TS_W-1:0]    acc_nxt;
  logic [TS_W:0]      diff;
  logic               expired;
  logic               full;
  logic [FILL_W-1:0]  fill_nxt;
  logic [FILL_W-1:0]  peak_nxt;
  logic [ERR_W-1:0]   err_nxt;
  logic               out_free;

  // shared multiply-add: one weighted time field per step
  always_comb begin
    unique case (step_r)
      STEP_DAY:  opnd = OPND_W'(day_r);
      STEP_HOUR: opnd = OPND_W'(hour_r);
      STEP_MIN:  opnd = OPND_W'(min_r);
      default:   opnd = OPND_W'(sec_r);
    endcase
  end

  assign prod    = opnd * step_weight(step_r);
  assign acc_nxt = acc_r + prod[TS_W-1:0];

  // borrow set means the stored entry is newer than the record
  assign diff    = {1'b0, acc_r} - {1'b0, rd_q};
  assign expired = !diff[TS_W] && (diff[TS_W-1:0] > window_r);

  assign full     = (fill_r >= FILL_W'(WINDOW_DEPTH));
  assign fill_nxt = full ? fill_r : fill_r + 1'b1;
  assign peak_nxt = (fill_nxt > peak_r) ? fill_nxt : peak_r;
  assign err_nxt  = ((class_r == err_class_r) && (err_r != '1)) ? err_r + 1'b1 : err_r;
  assign mem_we   = (state_r == S_PUSH);

  assign out_free = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[newest_r] <= acc_r;
    end
    rd_q <= store_mem[oldest_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      window_r     <= '0;
      err_class_r  <= ERR_CLASS_RST;
      oldest_r     <= '0;
      newest_r     <= '0;
      fill_r       <= '0;
      peak_r       <= '0;
      err_r        <= '0;
      ovf_r        <= 1'b0;
      step_r       <= STEP_DAY;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_WINDOW:    window_r    <= cfg_wdata;
          default:       err_class_r <= cfg_wdata[CLASS_W-1:0];
        endcase
      end

      if (out_tvalid_r && out_tready && (state_r != S_EMIT)) begin
        out_tvalid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            day_r   <= in_tdata[4:0];
            hour_r  <= in_tdata[9:5];
            min_r   <= in_tdata[15:10];
            sec_r   <= in_tdata[21:16];
            class_r <= in_tdata[25:22];
            acc_r   <= '0;
            step_r  <= STEP_DAY;
            state_r <= S_MAC;
          end
        end
        S_MAC: begin
          acc_r  <= acc_nxt;
          step_r <= step_r + 1'b1;
          if (step_r == STEP_SEC) begin
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if ((fill_r != '0) && expired) begin
            // retire oldest, wait for the read port to follow
            oldest_r <= next_ptr(oldest_r);
            fill_r   <= fill_r - 1'b1;
            state_r  <= S_SETTLE;
          end else begin
            state_r  <= S_PUSH;
          end
        end
        S_SETTLE: begin
          state_r <= S_SCAN;
        end
        S_PUSH: begin
          if (full) begin
            oldest_r <= next_ptr(oldest_r);
          end
          ovf_r    <= full;
          newest_r <= next_ptr(newest_r);
          fill_r   <= fill_nxt;
          peak_r   <= peak_nxt;
          err_r    <= err_nxt;
          state_r  <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= {3'b000, ovf_r, err_r, peak_r[CNT_W-1:0],
                             fill_r[CNT_W-1:0], acc_r};
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

[sv/swpec_checker.sv]
module swpec_checker
  import swpec_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [IN_DATA_W-1:0]  in_tdata,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result dropped or changed");

  // drop ready once a record is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("ready high right after a transaction");

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[32:22] != '0)
    else $error("window count is zero");

  a_peak_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[43:33] >= out_tdata[32:22])
    else $error("peak below window count");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[79:77] == 3'b000)
    else $error("result padding not zero");

endmodule

bind sliding_window_peak_event_count swpec_checker u_swpec_checker (.*);
